// ===== hdl/button_press_classifier_core_macros.svh =====
// Assertion macros for the button press classifier core.
`ifndef BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_CORE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence on the next clock edge.
`define BPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bpc_pkg.sv =====
// Types and constants shared by the button press classifier core.
package bpc_pkg;

  localparam int unsigned BUTTONS = 16;
  localparam logic [15:0] GROUP_MASK =
      (BUTTONS >= 16) ? 16'hFFFF : 16'((32'd1 << BUTTONS) - 32'd1);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_BOUNCE = 3'd1;
  localparam logic [2:0] PH_SHORT  = 3'd2;
  localparam logic [2:0] PH_SREL   = 3'd3;
  localparam logic [2:0] PH_LONG   = 3'd4;
  localparam logic [2:0] PH_LREL   = 3'd5;
  localparam logic [2:0] PH_PULSE  = 3'd6;

  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_SHORT_PRESS = 3'd1;
  localparam logic [2:0] EV_SHORT_REL   = 3'd2;
  localparam logic [2:0] EV_LONG_PRESS  = 3'd3;
  localparam logic [2:0] EV_LONG_REL    = 3'd4;
  localparam logic [2:0] EV_PULSE       = 3'd5;

  localparam logic [1:0] CFG_SHORT_PRESS  = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS   = 2'd1;
  localparam logic [1:0] CFG_REPEAT_PER   = 2'd2;

  typedef struct packed {
    logic [15:0] key_mask;
    logic [31:0] now_ms;
  } bpc_in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [2:0]  phase;
    logic [15:0] held_mask;
    logic [31:0] held_time;
    logic [31:0] idle_time;
    logic [15:0] pulses;
  } bpc_out_t;

endpackage

// ===== hdl/button_press_classifier_core.sv =====
// Button press classifier: debounce, short/long press and auto-repeat.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one sample tick per
//   transaction: the button mask and the free-running millisecond time.
//   Output channel (out_valid_o/out_ready_i/out_data_o) gives exactly one
//   result per tick: event, phase, latched mask, held and idle times, pulses.
//   Configuration port (cfg_we_i/cfg_idx_i/cfg_data_i) writes the short press,
//   long press and repeat period thresholds; write only while idle.
// Data path: an accepted tick waits in the input register, then passes through
//   the classifier logic into the result register.
// Throughput: one tick per cycle unless out_ready_i stalls, set by the single
//   pass from the input register through the phase update into the result register.
// Reset: phase returns to idle, accumulators, latched mask, pulse target and
//   last time clear, thresholds return to 50, 1000 and 250 ms, both stages
//   empty.
// Stall: while out_ready_i is low the result holds; one more tick waits in
//   the input register, after that in_ready_o drops.
`include "button_press_classifier_core_macros.svh"

module button_press_classifier_core
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  bpc_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output bpc_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] short_ms_q, long_ms_q, repeat_ms_q;

  logic        s1_valid_q;
  bpc_in_t     s1_q;
  logic        out_valid_q;
  bpc_out_t    out_q;
  logic        advance;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] latched_q, latched_d;
  logic [31:0] held_q, held_d;
  logic [31:0] idle_q, idle_d;
  logic [15:0] pulse_q, pulse_d;
  logic [31:0] next_at_q, next_at_d;
  logic [31:0] last_q;
  logic [2:0]  event_d;

  assign advance     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_ms_q  <= 16'd50;
      long_ms_q   <= 16'd1000;
      repeat_ms_q <= 16'd250;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHORT_PRESS: short_ms_q  <= cfg_data_i;
        CFG_LONG_PRESS:  long_ms_q   <= cfg_data_i;
        CFG_REPEAT_PER:  repeat_ms_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [15:0] mask;
    logic [31:0] delta;
    mask      = s1_q.key_mask & GROUP_MASK;
    delta     = s1_q.now_ms - last_q;
    phase_d   = phase_q;
    latched_d = latched_q;
    held_d    = held_q;
    idle_d    = idle_q;
    pulse_d   = pulse_q;
    next_at_d = next_at_q;
    event_d   = EV_NONE;

    if (latched_q != 16'd0) begin
      held_d = held_q + delta;
    end else begin
      idle_d = idle_q + delta;
    end

    if (phase_q == PH_SREL || phase_q == PH_LREL) begin
      latched_d = 16'd0;
      held_d    = 32'd0;
      idle_d    = 32'd0;
      pulse_d   = 16'd0;
      phase_d   = PH_IDLE;
    end else if (phase_q == PH_PULSE) begin
      phase_d = PH_LONG;
    end

    unique case (phase_d)
      PH_IDLE: begin
        if (mask != 16'd0) begin
          held_d    = 32'd0;
          pulse_d   = 16'd0;
          latched_d = mask;
          phase_d   = PH_BOUNCE;
        end
      end
      PH_BOUNCE: begin
        if (mask != latched_d) begin
          latched_d = 16'd0;
          held_d    = 32'd0;
          idle_d    = 32'd0;
          pulse_d   = 16'd0;
          phase_d   = PH_IDLE;
        end else if (held_d >= {16'd0, short_ms_q}) begin
          phase_d = PH_SHORT;
          event_d = EV_SHORT_PRESS;
        end
      end
      PH_SHORT: begin
        if (mask == 16'd0) begin
          phase_d = PH_SREL;
          event_d = EV_SHORT_REL;
        end else if (held_d >= {16'd0, long_ms_q}) begin
          next_at_d = held_d + {16'd0, repeat_ms_q};
          phase_d   = PH_LONG;
          event_d   = EV_LONG_PRESS;
        end
      end
      PH_LONG: begin
        if (mask == 16'd0) begin
          phase_d = PH_LREL;
          event_d = EV_LONG_REL;
        end else if (held_d >= next_at_q) begin
          next_at_d = held_d + {16'd0, repeat_ms_q};
          if (pulse_d != 16'hFFFF) begin
            pulse_d = pulse_d + 16'd1;
          end
          phase_d = PH_PULSE;
          event_d = EV_PULSE;
        end
      end
      default: begin
        latched_d = 16'd0;
        held_d    = 32'd0;
        idle_d    = 32'd0;
        pulse_d   = 16'd0;
        phase_d   = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      latched_q   <= 16'd0;
      held_q      <= 32'd0;
      idle_q      <= 32'd0;
      pulse_q     <= 16'd0;
      next_at_q   <= 32'd0;
      last_q      <= 32'd0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        latched_q   <= latched_d;
        held_q      <= held_d;
        idle_q      <= idle_d;
        pulse_q     <= pulse_d;
        next_at_q   <= next_at_d;
        last_q      <= s1_q.now_ms;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= in_data_i;
    end
    if (advance) begin
      out_q.event_res <= event_d;
      out_q.phase     <= phase_d;
      out_q.held_mask <= latched_d;
      out_q.held_time <= held_d;
      out_q.idle_time <= idle_d;
      out_q.pulses    <= pulse_d;
    end
  end

  `BPC_ASSERT(a_idle_mask, (phase_q == PH_IDLE) == (latched_q == 16'd0), "idle/mask mismatch")
  `BPC_ASSERT(a_pulse_cnt, !(out_valid_q && out_q.phase == PH_PULSE) || (out_q.pulses != 16'd0), "pulse phase with zero count")
  `BPC_ASSERT(a_short_ev, !(out_valid_q && out_q.event_res == EV_SHORT_PRESS) || (out_q.phase == PH_SHORT), "short press event outside short phase")
  `BPC_ASSERT_NEXT(a_adv_out, advance, out_valid_q, "result lost after advance")

endmodule

// ===== sim/bpc_checker.sv =====
// Checker that predicts and compares every result of the button press classifier.
`timescale 1ns / 100ps

module bpc_checker
  import bpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  bpc_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  bpc_out_t    out_data_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  logic [15:0] short_ms;
  logic [15:0] long_ms;
  logic [15:0] period_ms;

  logic [2:0]  phase_r;
  logic [15:0] latch_r;
  logic [31:0] held_r;
  logic [31:0] idle_r;
  logic [15:0] pulse_r;
  logic [31:0] next_at_r;
  logic [31:0] last_t;

  bpc_out_t expected_q[$];
  int       fail_cnt;

  function automatic void clear_press();
    latch_r = '0;
    held_r  = '0;
    idle_r  = '0;
    pulse_r = '0;
    phase_r = PH_IDLE;
  endfunction

  function automatic bpc_out_t classify_tick(bpc_in_t t);
    logic [15:0] mask;
    logic [31:0] delta;
    logic [2:0]  ev;
    bpc_out_t    r;
    mask  = t.key_mask & GROUP_MASK;
    delta = t.now_ms - last_t;
    ev    = EV_NONE;
    if (latch_r != '0) held_r = held_r + delta;
    else idle_r = idle_r + delta;
    if (phase_r == PH_SREL || phase_r == PH_LREL) clear_press();
    else if (phase_r == PH_PULSE) phase_r = PH_LONG;
    case (phase_r)
      PH_IDLE: begin
        if (mask != '0) begin
          held_r  = '0;
          pulse_r = '0;
          latch_r = mask;
          phase_r = PH_BOUNCE;
        end
      end
      PH_BOUNCE: begin
        if (mask != latch_r) begin
          clear_press();
        end else if (held_r >= {16'd0, short_ms}) begin
          phase_r = PH_SHORT;
          ev      = EV_SHORT_PRESS;
        end
      end
      PH_SHORT: begin
        if (mask == '0) begin
          phase_r = PH_SREL;
          ev      = EV_SHORT_REL;
        end else if (held_r >= {16'd0, long_ms}) begin
          next_at_r = held_r + {16'd0, period_ms};
          phase_r   = PH_LONG;
          ev        = EV_LONG_PRESS;
        end
      end
      PH_LONG: begin
        if (mask == '0) begin
          phase_r = PH_LREL;
          ev      = EV_LONG_REL;
        end else if (held_r >= next_at_r) begin
          next_at_r = held_r + {16'd0, period_ms};
          if (pulse_r != 16'hFFFF) pulse_r = pulse_r + 16'd1;
          phase_r = PH_PULSE;
          ev      = EV_PULSE;
        end
      end
      default: begin
        clear_press();
      end
    endcase
    last_t      = t.now_ms;
    r.event_res = ev;
    r.phase     = phase_r;
    r.held_mask = latch_r;
    r.held_time = held_r;
    r.idle_time = idle_r;
    r.pulses    = pulse_r;
    return r;
  endfunction

  function automatic int field_mismatch(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bpc_out_t want;
    int       bad;
    if (!rst_ni) begin
      short_ms  = 16'd50;
      long_ms   = 16'd1000;
      period_ms = 16'd250;
      clear_press();
      next_at_r = '0;
      last_t    = '0;
      expected_q.delete();
      fail_cnt  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SHORT_PRESS: short_ms  = cfg_data_i;
          CFG_LONG_PRESS:  long_ms   = cfg_data_i;
          CFG_REPEAT_PER:  period_ms = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(classify_tick(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result %0h with no tick pending", $time, out_data_i);
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          bad  = field_mismatch("event_res", 32'(want.event_res), 32'(out_data_i.event_res))
               + field_mismatch("phase", 32'(want.phase), 32'(out_data_i.phase))
               + field_mismatch("held_mask", 32'(want.held_mask), 32'(out_data_i.held_mask))
               + field_mismatch("held_time", want.held_time, out_data_i.held_time)
               + field_mismatch("idle_time", want.idle_time, out_data_i.idle_time)
               + field_mismatch("pulses", 32'(want.pulses), 32'(out_data_i.pulses));
          if (bad != 0) fail_cnt++;
        end
      end
    end
    fail_count_o <= fail_cnt;
    pending_o    <= expected_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top: stimulus, idling, threshold phases and verdict for the classifier core.
`timescale 1ns / 100ps

module tb_top;
  import bpc_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  bpc_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  bpc_out_t    out_data;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = CFG_SHORT_PRESS;
  logic [15:0] cfg_data  = '0;
  int          fail_count;
  int          pending;

  bpc_in_t     tick_q[$];
  logic [31:0] stamp;
  int unsigned step_max;
  int          burst_left = 0;
  int          gap_left   = 0;
  int          rx_cycle   = 0;
  int          rx_mode    = 0;
  int          hold_left  = 0;
  int          holds_done = 0;
  int          cycle_cnt  = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  button_press_classifier_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  bpc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // sender: bursts of ticks with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        in_data  <= tick_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern plus a few long hold-offs
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_done < 4 && in_valid &&
                   (holds_done == 0 ? rx_cycle >= 800 : $urandom_range(0, 2999) == 0)) begin
        hold_left = $urandom_range(100, 300);
        holds_done++;
        out_ready <= 1'b0;
      end else begin
        if (rx_cycle % 128 == 0) rx_mode = $urandom_range(0, 3);
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_tick(logic [15:0] mask, logic [31:0] now);
    bpc_in_t t;
    t.key_mask = mask;
    t.now_ms   = now;
    tick_q.push_back(t);
    stamp = now;
  endtask

  function automatic logic [31:0] next_step();
    if ($urandom_range(0, 63) == 0) return $urandom;
    return $urandom_range(0, step_max);
  endfunction

  function automatic logic [15:0] pick_mask();
    logic [15:0] m;
    case ($urandom_range(0, 3))
      0: m = 16'd1 << $urandom_range(0, 15);
      1: m = 16'hFFFF;
      default: m = 16'($urandom);
    endcase
    if (m == '0) m = 16'h0001;
    return m;
  endfunction

  task automatic apply_thresholds(logic [15:0] s, logic [15:0] l, logic [15:0] p);
    int unsigned top_v;
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SHORT_PRESS;
    cfg_data <= s;
    @(posedge clk_i);
    cfg_idx  <= CFG_LONG_PRESS;
    cfg_data <= l;
    @(posedge clk_i);
    cfg_idx  <= CFG_REPEAT_PER;
    cfg_data <= p;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    top_v = s;
    if (l > top_v) top_v = l;
    if (p > top_v) top_v = p;
    step_max = top_v / 6 + 1;
  endtask

  task automatic random_ticks(int n);
    int          made;
    int          hold_n;
    logic [15:0] m;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 6) == 0) begin
        push_tick(16'($urandom), stamp + next_step());
        made++;
      end else begin
        m      = pick_mask();
        hold_n = $urandom_range(1, 40);
        for (int i = 0; i < hold_n; i++) begin
          if ($urandom_range(0, 24) == 0) m = pick_mask();
          push_tick(m, stamp + next_step());
          made++;
        end
        repeat ($urandom_range(1, 3)) begin
          push_tick(16'd0, stamp + next_step());
          made++;
        end
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk_i); while (tick_q.size() != 0 || in_valid || pending != 0 || out_valid);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    stamp    = '0;
    step_max = 1000 / 6 + 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds: 50, 1000, 250
    push_tick(16'h0000, 32'hFFFF_FFF0);
    push_tick(16'h0000, 32'h0000_0010);
    push_tick(16'hFFFF, 32'h0000_0020);
    push_tick(16'hFFFF, 32'h0000_0060);
    push_tick(16'h00FF, 32'h0000_0100);
    push_tick(16'h0000, 32'h0000_0110);
    push_tick(16'h0000, 32'h0000_0120);
    push_tick(16'h8000, 32'h0000_0130);
    push_tick(16'h0001, 32'h0000_0140);
    push_tick(16'h0001, 32'h0000_0150);
    push_tick(16'h0001, 32'h0000_01A0);
    push_tick(16'h0001, 32'h0000_0600);
    push_tick(16'h0003, 32'h0000_0700);
    push_tick(16'h0003, 32'h0000_0701);
    push_tick(16'h0003, 32'h0000_0800);
    push_tick(16'h0000, 32'h0000_0810);
    push_tick(16'hABCD, 32'h0000_0820);
    push_tick(16'hABCD, 32'hFFFF_F000);
    push_tick(16'hABCD, 32'hFFFF_F100);
    push_tick(16'hABCD, 32'h0000_1000);
    push_tick(16'h0000, 32'h0000_1010);
    push_tick(16'h0000, 32'h0000_1020);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: apply_thresholds(16'd0, 16'd0, 16'd0);
        1: apply_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: apply_thresholds(16'd300, 16'd40, 16'd0);
        3: apply_thresholds(16'd20, 16'd200, 16'd30);
        4: apply_thresholds(16'($urandom_range(0, 400)), 16'($urandom_range(0, 2000)),
                            16'($urandom_range(0, 300)));
        default: apply_thresholds(16'd50, 16'd1000, 16'd250);
      endcase
      random_ticks(230);
      drain();
    end

    // hold one press through a long run of pulses
    apply_thresholds(16'd0, 16'd0, 16'd0);
    for (int i = 0; i < 100; i++) push_tick(16'h5A5A, stamp + $urandom_range(0, 3));
    push_tick(16'h0000, stamp + 32'd1);
    push_tick(16'h0000, stamp + 32'd1);
    drain();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bpc_pkg.sv
hdl/button_press_classifier_core.sv
sim/bpc_checker.sv
sim/tb_top.sv
